FILE: src/dsefd_pkg.sv
// shared constants, types and helpers for the dshot edge frame decoder
`default_nettype none

package dsefd_pkg;

    // field widths fixed by the interface
    localparam int CAPTURE_W   = 16;
    localparam int GAP_W       = 16;
    localparam int PCT_W       = 7;
    localparam int THROTTLE_W  = 11;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;

    // frame layout
    localparam int FRAME_BITS  = 16;
    localparam int PAYLOAD_W   = 12;
    localparam int CRC_W       = 4;

    // defaults
    localparam int DEF_TIMER_WIDTH = 16;
    localparam int DEF_QUEUE_DEPTH = 4;
    localparam int GAP_RESET       = 300;
    localparam int PCT_RESET       = 60;
    localparam int HUNDRED         = 100;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESHOLD = 1'd1;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // xor of the three payload nibbles
    function automatic logic [CRC_W-1:0] nibble_xor(input logic [PAYLOAD_W-1:0] p);
        return p[3:0] ^ p[7:4] ^ p[11:8];
    endfunction

endpackage

`default_nettype wire

FILE: src/dsefd_front.sv
// edge front end: tracks frame position and emits per-bit high time and period
`default_nettype none

module dsefd_front #(
    parameter int TIMER_WIDTH = dsefd_pkg::DEF_TIMER_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [dsefd_pkg::CAPTURE_W-1:0] i_capture_time,
    input  logic [dsefd_pkg::GAP_W-1:0]   i_gap_ticks,
    output logic                          o_push,
    output logic [TIMER_WIDTH-1:0]        o_high,
    output logic [TIMER_WIDTH-1:0]        o_period,
    output logic                          o_last
);
    import dsefd_pkg::*;

    localparam int CW    = (TIMER_WIDTH > CAPTURE_W) ? TIMER_WIDTH : CAPTURE_W;
    localparam int CNT_W = $clog2(FRAME_BITS + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(FRAME_BITS);

    logic [TIMER_WIDTH-1:0] r_prev, n_prev;
    logic [TIMER_WIDTH-1:0] r_rise, n_rise;
    logic [TIMER_WIDTH-1:0] r_high, n_high;
    logic [TIMER_WIDTH-1:0] r_period, n_period;
    logic                   r_expect_fall, n_expect_fall;
    logic [CNT_W-1:0]       r_bit_count, n_bit_count;

    logic [CW-1:0]          cap_ext;
    logic [TIMER_WIDTH-1:0] cap;
    logic [TIMER_WIDTH-1:0] delta;
    logic [TIMER_WIDTH-1:0] rise_span;
    logic [CNT_W-1:0]       count_inc;
    logic                   gap_hit;

    // timer arithmetic, all timestamp differences modulo the timer width
    assign cap_ext   = CW'(i_capture_time);
    assign cap       = cap_ext[TIMER_WIDTH-1:0];
    assign delta     = cap - r_prev;
    assign rise_span = cap - r_rise;
    assign count_inc = r_bit_count + 1'b1;
    assign gap_hit   = CW'(delta) > CW'(i_gap_ticks);

    // edge classification
    always_comb begin
        n_prev        = r_prev;
        n_rise        = r_rise;
        n_high        = r_high;
        n_period      = r_period;
        n_expect_fall = r_expect_fall;
        n_bit_count   = r_bit_count;
        o_push        = 1'b0;
        o_high        = r_high;
        o_period      = rise_span;
        o_last        = 1'b0;
        if (i_accept) begin
            n_prev = cap;
            if (gap_hit) begin
                // gap edge is rise of bit 0
                n_bit_count   = '0;
                n_rise        = cap;
                n_expect_fall = 1'b1;
            end else if (!r_expect_fall) begin
                if (r_bit_count < FULL_COUNT) begin
                    // this rise closes the period of the previous bit
                    o_push        = (r_bit_count != '0);
                    n_period      = rise_span;
                    n_rise        = cap;
                    n_expect_fall = 1'b1;
                end
            end else begin
                n_expect_fall = 1'b0;
                if (count_inc == FULL_COUNT) begin
                    // last bit reuses the previous period
                    o_push      = 1'b1;
                    o_high      = rise_span;
                    o_period    = r_period;
                    o_last      = 1'b1;
                    n_bit_count = '0;
                end else begin
                    n_high      = rise_span;
                    n_bit_count = count_inc;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev        <= '0;
            r_expect_fall <= 1'b0;
            r_bit_count   <= '0;
        end else begin
            r_prev        <= n_prev;
            r_expect_fall <= n_expect_fall;
            r_bit_count   <= n_bit_count;
        end
    end

    // timestamps
    always_ff @(posedge i_clk) begin
        r_rise   <= n_rise;
        r_high   <= n_high;
        r_period <= n_period;
    end

endmodule

`default_nettype wire

FILE: src/dsefd_queue.sv
// short fifo of per-bit timing entries between front and back
`default_nettype none

module dsefd_queue #(
    parameter int WIDTH = 33,
    parameter int DEPTH = dsefd_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_data,
    output dsefd_pkg::t_q_status o_status
);
    import dsefd_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [NW-1:0] FULL_CNT = NW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [NW-1:0]    r_count;

    assign o_data         = r_mem[r_rd];
    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/dsefd_back.sv
// bit decode back end: duty compare per bit, shift, checksum and result register
`default_nettype none

module dsefd_back #(
    parameter int TIMER_WIDTH = dsefd_pkg::DEF_TIMER_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [dsefd_pkg::PCT_W-1:0]     i_pct,
    input  dsefd_pkg::t_q_status            i_q_status,
    input  logic [TIMER_WIDTH-1:0]          i_high,
    input  logic [TIMER_WIDTH-1:0]          i_period,
    input  logic                            i_last,
    output logic                            o_pop,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [dsefd_pkg::THROTTLE_W-1:0] o_throttle,
    output logic                            o_telemetry_request
);
    import dsefd_pkg::*;

    localparam int PW = TIMER_WIDTH + PCT_W;

    logic                  r_a_valid;
    logic                  r_a_last;
    logic [PW-1:0]         r_a_high_x;
    logic [PW-1:0]         r_a_per_x;
    logic [FRAME_BITS-1:0] r_raw;
    logic                  r_out_valid;
    logic [THROTTLE_W-1:0] r_throttle;
    logic                  r_telem;

    logic                  advance;
    logic                  bit_one;
    logic [FRAME_BITS-1:0] raw_next;
    logic [PAYLOAD_W-1:0]  payload;
    logic                  emit;

    // whole back pipe moves when the result register can take a value
    assign advance = !r_out_valid || !i_out_stall;
    assign o_pop   = advance && !i_q_status.empty;

    // bit decision and frame check
    assign bit_one  = r_a_high_x > r_a_per_x;
    assign raw_next = {r_raw[FRAME_BITS-2:0], bit_one};
    assign payload  = raw_next[FRAME_BITS-1:CRC_W];
    assign emit     = r_a_valid && r_a_last && (nibble_xor(payload) == raw_next[CRC_W-1:0]);

    // scaling stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (advance) begin
            r_a_valid <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_last   <= i_last;
            r_a_high_x <= PW'(i_high) * PW'(HUNDRED);
            r_a_per_x  <= PW'(i_period) * PW'(i_pct);
        end
    end

    // bit shift register
    always_ff @(posedge i_clk) begin
        if (advance && r_a_valid) begin
            r_raw <= raw_next;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_throttle <= payload[PAYLOAD_W-1:1];
            r_telem    <= payload[0];
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_throttle          = r_throttle;
    assign o_telemetry_request = r_telem;

endmodule

`default_nettype wire

FILE: src/dshot_edge_frame_decoder_top.sv
// top level of the dshot edge frame decoder
//
//  channel   direction  handshake              payload
//  in        input      i_in_valid / o_in_stall  i_capture_time
//  out       output     o_out_valid / i_out_stall  o_throttle, o_telemetry_request
//  cfg       input      i_cfg_we                i_cfg_index, i_cfg_data
//
// the front takes one edge per cycle; it stalls only while the bit queue is full
// the back decodes one queued bit per cycle, multiply then compare, if not stalled
// a good frame passes queue, scaling stage and result register to reach the output
// synchronous active-low reset clears control state and loads register defaults
// an output stall holds the result and backs up into the queue, then the input
`default_nettype none

module dshot_edge_frame_decoder_top #(
    parameter int TIMER_WIDTH = dsefd_pkg::DEF_TIMER_WIDTH,
    parameter int QUEUE_DEPTH = dsefd_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [dsefd_pkg::CAPTURE_W-1:0]  i_capture_time,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [dsefd_pkg::THROTTLE_W-1:0] o_throttle,
    output logic                             o_telemetry_request,
    input  logic                             i_cfg_we,
    input  logic [dsefd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dsefd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dsefd_pkg::*;

    localparam int QW = 2 * TIMER_WIDTH + 1;

    logic [GAP_W-1:0] r_gap_ticks;
    logic [PCT_W-1:0] r_one_threshold_pct;

    logic                   in_accept;
    logic                   push;
    logic                   pop;
    logic [TIMER_WIDTH-1:0] f_high, f_period, q_high, q_period;
    logic                   f_last, q_last;
    logic [QW-1:0]          q_out;
    t_q_status              q_status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_ticks         <= GAP_W'(GAP_RESET);
            r_one_threshold_pct <= PCT_W'(PCT_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GAP_TICKS:     r_gap_ticks         <= i_cfg_data[GAP_W-1:0];
                CFG_ONE_THRESHOLD: r_one_threshold_pct <= i_cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // input transfer
    assign o_in_stall = q_status.full;
    assign in_accept  = i_in_valid && !o_in_stall;

    dsefd_front #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_capture_time (i_capture_time),
        .i_gap_ticks    (r_gap_ticks),
        .o_push         (push),
        .o_high         (f_high),
        .o_period       (f_period),
        .o_last         (f_last)
    );

    dsefd_queue #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   ({f_high, f_period, f_last}),
        .i_pop    (pop),
        .o_data   (q_out),
        .o_status (q_status)
    );

    assign {q_high, q_period, q_last} = q_out;

    dsefd_back #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_pct               (r_one_threshold_pct),
        .i_q_status          (q_status),
        .i_high              (q_high),
        .i_period            (q_period),
        .i_last              (q_last),
        .o_pop               (pop),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_throttle          (o_throttle),
        .o_telemetry_request (o_telemetry_request)
    );

endmodule

`default_nettype wire

FILE: src/dsefd_checker.sv
// port-level checks for the dshot edge frame decoder, bound to the top level
`default_nettype none

module dsefd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a frame needs a full walk of bits, so results never come in adjacent cycles
    a_result_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> !o_out_valid)
        else $error("two results in adjacent cycles");

    // the queue only fills through an input transfer
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && !o_in_stall))
        else $error("input stall without a transfer");

endmodule

bind dshot_edge_frame_decoder_top dsefd_checker u_chk (.*);

`default_nettype wire
